// ===== hdl/ehx_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ehx_pkg
// Shared types and constants of the Ethernet / IP header extractor: the
// field-update codes passed from the classifier to the field collector.
// ----------------------------------------------------------------------------
package ehx_pkg;

	localparam int unsigned QUEUE_DEPTH_DEF = 4;
	localparam int unsigned OUT_W = 400;

	localparam logic [15:0] TPID_8021Q = 16'h8100;
	localparam logic [3:0] VER_IPV4 = 4'd4;
	localparam logic [3:0] VER_IPV6 = 4'd6;
	localparam logic [6:0] POS_MAX = 7'd127;

	typedef logic [3:0] op_t;

	localparam op_t OP_NONE = 4'd0;
	localparam op_t OP_DMAC = 4'd1;
	localparam op_t OP_SMAC = 4'd2;
	localparam op_t OP_TYPE = 4'd3;
	localparam op_t OP_TAG = 4'd4;
	localparam op_t OP_VER4 = 4'd5;
	localparam op_t OP_VER = 4'd6;
	localparam op_t OP_LEN = 4'd7;
	localparam op_t OP_PROTO = 4'd8;
	localparam op_t OP_SRCH = 4'd9;
	localparam op_t OP_SRCL = 4'd10;
	localparam op_t OP_DSTH = 4'd11;
	localparam op_t OP_DSTL = 4'd12;

	typedef struct packed {
		logic [7:0] data;
		op_t op;
		logic clear;
		logic fire;
	} entry_t;

endpackage

// ===== hdl/ehx_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ehx_front
// Byte classifier: tracks the frame position, the VLAN tag and the IP
// version, and turns each header byte into a field-update request.
// ----------------------------------------------------------------------------
module ehx_front
	import ehx_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,     // data_byte[7:0]
	input  logic       s_tuser,     // frame_start
	input  logic       q_full,
	output logic       push,
	output entry_t     push_entry
);

	logic [6:0] pos_q;
	logic       done_q;
	logic       tagged_q;
	logic [3:0] ver_q;
	logic [7:0] type_hi_q;

	logic [6:0] pos_eff;
	logic       done_eff;
	logic       tag_eff;
	logic [3:0] ver_eff;
	logic [6:0] ip_start;
	logic [6:0] r;
	logic [3:0] ver_new;
	op_t        op;
	logic       fire;
	logic       accept;

	assign s_tready = !q_full;
	assign accept = s_tvalid && s_tready;

	assign pos_eff = s_tuser ? 7'd0 : pos_q;
	assign done_eff = s_tuser ? 1'b0 : done_q;
	assign tag_eff = s_tuser ? 1'b0 : tagged_q;
	assign ver_eff = s_tuser ? 4'd0 : ver_q;
	assign ip_start = tag_eff ? 7'd18 : 7'd14;
	assign r = pos_eff - ip_start;
	assign ver_new = s_tdata[7:4];

	always_comb begin
		op = OP_NONE;
		fire = 1'b0;
		if (pos_eff < 7'd6) begin
			op = OP_DMAC;
		end else if (pos_eff < 7'd12) begin
			op = OP_SMAC;
		end else if (pos_eff < 7'd14) begin
			if (pos_eff == 7'd13 && {type_hi_q, s_tdata} == TPID_8021Q) begin
				op = OP_TAG;
			end else begin
				op = OP_TYPE;
			end
		end else if (pos_eff < ip_start) begin
			if (pos_eff >= 7'd16) begin
				op = OP_TYPE;
			end
		end else if (r == 7'd0) begin
			op = (ver_new == VER_IPV4) ? OP_VER4 : OP_VER;
			fire = (ver_new != VER_IPV4) && (ver_new != VER_IPV6);
		end else if (ver_eff == VER_IPV4) begin
			if (r == 7'd2 || r == 7'd3) begin
				op = OP_LEN;
			end else if (r == 7'd9) begin
				op = OP_PROTO;
			end else if (r >= 7'd12 && r < 7'd16) begin
				op = OP_SRCL;
			end else if (r >= 7'd16 && r < 7'd20) begin
				op = OP_DSTL;
			end
			fire = (r >= 7'd19);
		end else begin
			if (r == 7'd4 || r == 7'd5) begin
				op = OP_LEN;
			end else if (r == 7'd6) begin
				op = OP_PROTO;
			end else if (r >= 7'd8 && r < 7'd16) begin
				op = OP_SRCH;
			end else if (r >= 7'd16 && r < 7'd24) begin
				op = OP_SRCL;
			end else if (r >= 7'd24 && r < 7'd32) begin
				op = OP_DSTH;
			end else if (r >= 7'd32 && r < 7'd40) begin
				op = OP_DSTL;
			end
			fire = (r >= 7'd39);
		end
	end

	assign push = accept && !done_eff;
	assign push_entry = '{data: s_tdata, op: op, clear: s_tuser, fire: fire};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			done_q <= 1'b1;
			tagged_q <= 1'b0;
			ver_q <= '0;
		end else if (push) begin
			pos_q <= (pos_eff < POS_MAX) ? pos_eff + 7'd1 : pos_eff;
			done_q <= fire;
			tagged_q <= tag_eff || (op == OP_TAG);
			ver_q <= (op == OP_VER4 || op == OP_VER) ? ver_new : ver_eff;
		end
	end

	always_ff @(posedge clk) begin
		if (push && pos_eff == 7'd12) begin
			type_hi_q <= s_tdata;
		end
	end

endmodule

// ===== hdl/ehx_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ehx_queue
// Small request queue between the classifier and the field collector.
// ----------------------------------------------------------------------------
module ehx_queue
	import ehx_pkg::*;
#(
	parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	output logic   full,
	input  logic   pop,
	output logic   head_valid,
	output entry_t head
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	entry_t           mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full = (count_q == CNT_FULL);
	assign head_valid = (count_q != '0);
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

// ===== hdl/ehx_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ehx_back
// Field collector: applies queued update requests to the header field
// registers and loads the result register when a header is complete.
// ----------------------------------------------------------------------------
module ehx_back
	import ehx_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             head_valid,
	input  entry_t           head,
	output logic             pop,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata,
	output logic             m_tuser
);

	logic [47:0] dmac_q, smac_q;
	logic [15:0] type_q;
	logic        tagged_q;
	logic [3:0]  ver_q, ihl_q;
	logic [15:0] len_q;
	logic [7:0]  proto_q;
	logic [63:0] srch_q, srcl_q, dsth_q, dstl_q;

	logic [47:0] dmac_b, smac_b, dmac_n, smac_n;
	logic [15:0] type_b, type_n, len_b, len_n;
	logic        tagged_b, tagged_n;
	logic [3:0]  ver_b, ver_n, ihl_b, ihl_n;
	logic [7:0]  proto_b, proto_n;
	logic [63:0] srch_b, srcl_b, dsth_b, dstl_b;
	logic [63:0] srch_n, srcl_n, dsth_n, dstl_n;
	logic [7:0]  b;

	assign b = head.data;
	assign pop = head_valid && (!head.fire || !m_tvalid || m_tready);

	always_comb begin
		dmac_b = head.clear ? '0 : dmac_q;
		smac_b = head.clear ? '0 : smac_q;
		type_b = head.clear ? '0 : type_q;
		tagged_b = head.clear ? 1'b0 : tagged_q;
		ver_b = head.clear ? '0 : ver_q;
		ihl_b = head.clear ? '0 : ihl_q;
		len_b = head.clear ? '0 : len_q;
		proto_b = head.clear ? '0 : proto_q;
		srch_b = head.clear ? '0 : srch_q;
		srcl_b = head.clear ? '0 : srcl_q;
		dsth_b = head.clear ? '0 : dsth_q;
		dstl_b = head.clear ? '0 : dstl_q;

		dmac_n = dmac_b;
		smac_n = smac_b;
		type_n = type_b;
		tagged_n = tagged_b;
		ver_n = ver_b;
		ihl_n = ihl_b;
		len_n = len_b;
		proto_n = proto_b;
		srch_n = srch_b;
		srcl_n = srcl_b;
		dsth_n = dsth_b;
		dstl_n = dstl_b;

		unique case (head.op)
			OP_NONE: ;
			OP_DMAC: dmac_n = {dmac_b[39:0], b};
			OP_SMAC: smac_n = {smac_b[39:0], b};
			OP_TYPE: type_n = {type_b[7:0], b};
			OP_TAG: begin
				type_n = {type_b[7:0], b};
				tagged_n = 1'b1;
			end
			OP_VER4: begin
				ver_n = b[7:4];
				ihl_n = b[3:0];
			end
			OP_VER: ver_n = b[7:4];
			OP_LEN: len_n = {len_b[7:0], b};
			OP_PROTO: proto_n = b;
			OP_SRCH: srch_n = {srch_b[55:0], b};
			OP_SRCL: srcl_n = {srcl_b[55:0], b};
			OP_DSTH: dsth_n = {dsth_b[55:0], b};
			OP_DSTL: dstl_n = {dstl_b[55:0], b};
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			dmac_q <= dmac_n;
			smac_q <= smac_n;
			type_q <= type_n;
			tagged_q <= tagged_n;
			ver_q <= ver_n;
			ihl_q <= ihl_n;
			len_q <= len_n;
			proto_q <= proto_n;
			srch_q <= srch_n;
			srcl_q <= srcl_n;
			dsth_q <= dsth_n;
			dstl_q <= dstl_n;
		end
		if (pop && head.fire) begin
			m_tdata <= {dstl_n, dsth_n, srcl_n, srch_n, proto_n, len_n,
				ihl_n, ver_n, type_n, smac_n, dmac_n};
			m_tuser <= tagged_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (pop && head.fire) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

endmodule

// ===== hdl/ethernet_ip_header_extractor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ethernet_ip_header_extractor
// Ethernet/802.1Q/IPv4/IPv6 header extractor, one byte per cycle if s_tready.
// ----------------------------------------------------------------------------
// throughput: one byte per cycle if s_tready; at most one result per frame
// result: the last header byte's request is queued, and the result register
//   loads when the field collector pops that request
// reset: arst_n asynchronous; result register empty, bytes ignored until
//   the first frame start
module ethernet_ip_header_extractor
	import ehx_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [7:0]       s_tdata,   // data_byte[7:0]
	input  logic             s_tuser,   // frame_start
	output logic             m_tvalid,
	input  logic             m_tready,
	// dst_mac[47:0], src_mac[95:48], eth_type[111:96], ip_version[115:112],
	// ihl_words[119:116], ip_length[135:120], protocol[143:136],
	// src_addr_high[207:144], src_addr_low[271:208],
	// dst_addr_high[335:272], dst_addr_low[399:336]
	output logic [OUT_W-1:0] m_tdata,
	output logic             m_tuser    // vlan_tagged
);

	logic   push;
	entry_t push_entry;
	logic   q_full;
	logic   pop;
	logic   head_valid;
	entry_t head;

	ehx_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	ehx_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	ehx_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser)
	);

endmodule

// ===== hdl/ehx_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ehx_checker
// Port-level checks of the header extractor result stream.
// ----------------------------------------------------------------------------
module ehx_checker
	import ehx_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata,
	input logic             m_tuser
);

	logic [3:0] ver;
	assign ver = m_tdata[115:112];

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_ihl_v4_only: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && ver != VER_IPV4 |-> m_tdata[119:116] == 4'd0)
		else $error("header length set on non-ipv4 result");

	a_v4_addr: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && ver == VER_IPV4 |->
			m_tdata[207:144] == '0 && m_tdata[335:272] == '0 &&
			m_tdata[271:240] == '0 && m_tdata[399:368] == '0)
		else $error("ipv4 address beyond 32 bits");

	a_unknown_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && ver != VER_IPV4 && ver != VER_IPV6 |->
			m_tdata[399:120] == '0)
		else $error("unknown version result carries ip fields");

endmodule

bind ethernet_ip_header_extractor ehx_checker u_ehx_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// ===== test/ethernet_ip_header_extractor_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ethernet_ip_header_extractor_tb
// Sends Ethernet frames (plain, 802.1Q tagged, stacked tags, IPv4 with and
// without options, IPv6, unknown versions, cut-short frames and noise) one
// byte per request with bursty timing, rebuilds each header result in a
// behavioral parser and compares every field of each result the block
// gives while the result side stalls on its own pattern.
// ----------------------------------------------------------------------------
module ethernet_ip_header_extractor_tb;
	import ehx_pkg::*;

	localparam logic [15:0] ETH_IPV4 = 16'h0800;
	localparam logic [15:0] ETH_IPV6 = 16'h86DD;
	localparam int ETH_HDR_BYTES = 14;
	localparam int VLAN_HDR_BYTES = 18;
	localparam int IPV4_LAST = 19;
	localparam int IPV6_LAST = 39;
	localparam int ITEM_COUNT = 1300;

	typedef struct {
		logic [47:0] dmac;
		logic [47:0] smac;
		logic [15:0] etype;
		logic        vlan;
		logic [3:0]  ver;
		logic [3:0]  ihl;
		logic [15:0] len;
		logic [7:0]  proto;
		logic [63:0] src_hi;
		logic [63:0] src_lo;
		logic [63:0] dst_hi;
		logic [63:0] dst_lo;
	} hdr_t;

	logic             clk;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [7:0]       s_tdata;
	logic             s_tuser;
	logic             m_tvalid;
	logic             m_tready;
	logic [OUT_W-1:0] m_tdata;
	logic             m_tuser;

	// header parser state
	logic [6:0]  pos_r = '0;
	logic        done_r = 1'b1;
	logic [47:0] dmac_r = '0;
	logic [47:0] smac_r = '0;
	logic [15:0] type_r = '0;
	logic        vlan_r = 1'b0;
	logic [3:0]  ver_r = '0;
	logic [3:0]  ihl_r = '0;
	logic [15:0] len_r = '0;
	logic [7:0]  proto_r = '0;
	logic [63:0] src_r [2] = '{default: '0};
	logic [63:0] dst_r [2] = '{default: '0};

	hdr_t       hdr_q [$];
	hdr_t       seen_hdr;
	logic [7:0] frame_q [$];
	int         errors = 0;
	int         sent_bytes = 0;
	int         burst_left = 0;

	ethernet_ip_header_extractor DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	task automatic parse_byte(input logic [7:0] b, input logic st);
		int p;
		int r;
		int ip_start;
		logic fire;
		hdr_t h;
		fire = 1'b0;
		if (st) begin
			dmac_r = '0;
			smac_r = '0;
			type_r = '0;
			vlan_r = 1'b0;
			ver_r = '0;
			ihl_r = '0;
			len_r = '0;
			proto_r = '0;
			src_r = '{default: '0};
			dst_r = '{default: '0};
			pos_r = '0;
			done_r = 1'b0;
		end
		if (!done_r) begin
			p = int'(pos_r);
			ip_start = vlan_r ? VLAN_HDR_BYTES : ETH_HDR_BYTES;
			if (p < 6) begin
				dmac_r = {dmac_r[39:0], b};
			end else if (p < 12) begin
				smac_r = {smac_r[39:0], b};
			end else if (p < ETH_HDR_BYTES) begin
				type_r = {type_r[7:0], b};
				if (p == 13 && type_r == TPID_8021Q)
					vlan_r = 1'b1;
			end else if (p < ip_start) begin
				// tag control bytes skipped, inner type follows
				if (p >= 16)
					type_r = {type_r[7:0], b};
			end else begin
				r = p - ip_start;
				if (r == 0) begin
					ver_r = b[7:4];
					if (ver_r == VER_IPV4)
						ihl_r = b[3:0];
					else if (ver_r != VER_IPV6)
						fire = 1'b1;
				end else if (ver_r == VER_IPV4) begin
					if (r == 2 || r == 3)
						len_r = {len_r[7:0], b};
					else if (r == 9)
						proto_r = b;
					else if (r >= 12 && r < 16)
						src_r[1] = {32'b0, src_r[1][23:0], b};
					else if (r >= 16 && r < 20)
						dst_r[1] = {32'b0, dst_r[1][23:0], b};
					if (r >= IPV4_LAST)
						fire = 1'b1;
				end else begin
					if (r == 4 || r == 5)
						len_r = {len_r[7:0], b};
					else if (r == 6)
						proto_r = b;
					else if (r >= 8 && r < 16)
						src_r[0] = {src_r[0][55:0], b};
					else if (r >= 16 && r < 24)
						src_r[1] = {src_r[1][55:0], b};
					else if (r >= 24 && r < 32)
						dst_r[0] = {dst_r[0][55:0], b};
					else if (r >= 32 && r < 40)
						dst_r[1] = {dst_r[1][55:0], b};
					if (r >= IPV6_LAST)
						fire = 1'b1;
				end
			end
			if (pos_r != POS_MAX)
				pos_r = pos_r + 7'd1;
			if (fire) begin
				done_r = 1'b1;
				h.dmac = dmac_r;
				h.smac = smac_r;
				h.etype = type_r;
				h.vlan = vlan_r;
				h.ver = ver_r;
				h.ihl = ihl_r;
				h.len = len_r;
				h.proto = proto_r;
				h.src_hi = src_r[0];
				h.src_lo = src_r[1];
				h.dst_hi = dst_r[0];
				h.dst_lo = dst_r[1];
				hdr_q.push_back(h);
			end
		end
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (hdr_q.size() == 0) begin
				$display("%0t: unexpected header result, expected none, actual %h",
					$time, m_tdata);
				errors++;
			end else begin
				seen_hdr = hdr_q.pop_front();
				check_field("dst_mac", 64'(seen_hdr.dmac), 64'(m_tdata[47:0]));
				check_field("src_mac", 64'(seen_hdr.smac), 64'(m_tdata[95:48]));
				check_field("eth_type", 64'(seen_hdr.etype), 64'(m_tdata[111:96]));
				check_field("vlan_tagged", 64'(seen_hdr.vlan), 64'(m_tuser));
				check_field("ip_version", 64'(seen_hdr.ver), 64'(m_tdata[115:112]));
				check_field("ihl_words", 64'(seen_hdr.ihl), 64'(m_tdata[119:116]));
				check_field("ip_length", 64'(seen_hdr.len), 64'(m_tdata[135:120]));
				check_field("protocol", 64'(seen_hdr.proto), 64'(m_tdata[143:136]));
				check_field("src_addr_high", seen_hdr.src_hi, m_tdata[207:144]);
				check_field("src_addr_low", seen_hdr.src_lo, m_tdata[271:208]);
				check_field("dst_addr_high", seen_hdr.dst_hi, m_tdata[335:272]);
				check_field("dst_addr_low", seen_hdr.dst_lo, m_tdata[399:336]);
			end
		end
	end

	// result side: ready runs with short and occasional long stalls
	initial begin
		int run;
		m_tready = 1'b1;
		forever begin
			m_tready = 1'b1;
			run = $urandom_range(1, 30);
			repeat (run) @(negedge clk);
			run = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 25) : $urandom_range(0, 3);
			if (run != 0) begin
				m_tready = 1'b0;
				repeat (run) @(negedge clk);
			end
		end
	end

	initial begin
		#2000000;
		$display("TB_ERROR");
		$finish;
	end

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_byte(input logic [7:0] d, input logic st);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				s_tvalid = 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		s_tvalid = 1'b1;
		s_tdata = d;
		s_tuser = st;
		do @(posedge clk); while (!s_tready);
		parse_byte(d, st);
		sent_bytes++;
		burst_left--;
		@(negedge clk);
	endtask

	task automatic send_frame;
		foreach (frame_q[i])
			send_byte(frame_q[i], i == 0);
	endtask

	task automatic drain;
		s_tvalid = 1'b0;
		while (hdr_q.size() != 0)
			@(negedge clk);
	endtask

	function automatic logic [63:0] rand_val(input int bits);
		logic [63:0] v;
		case ($urandom_range(0, 9))
			0: v = '0;
			1: v = '1;
			default: v = {$urandom, $urandom};
		endcase
		if (bits < 64)
			v = v & ((64'd1 << bits) - 64'd1);
		return v;
	endfunction

	task automatic put_bytes(input logic [127:0] v, input int n);
		int i;
		for (i = n - 1; i >= 0; i--)
			frame_q.push_back(v[i*8 +: 8]);
	endtask

	task automatic put_eth(input logic [47:0] dmac, input logic [47:0] smac,
			input logic vlan, input logic [15:0] etype);
		frame_q.delete();
		put_bytes(128'(dmac), 6);
		put_bytes(128'(smac), 6);
		if (vlan) begin
			put_bytes(128'(TPID_8021Q), 2);
			put_bytes(128'($urandom), 2);
		end
		put_bytes(128'(etype), 2);
	endtask

	task automatic put_ipv4(input logic [3:0] ihl, input logic [15:0] len,
			input logic [7:0] proto, input logic [31:0] src, input logic [31:0] dst);
		int i;
		put_bytes(128'({VER_IPV4, ihl}), 1);
		put_bytes(128'($urandom), 1);
		put_bytes(128'(len), 2);
		put_bytes(128'($urandom), 4);
		put_bytes(128'($urandom), 1);
		put_bytes(128'(proto), 1);
		put_bytes(128'($urandom), 2);
		put_bytes(128'(src), 4);
		put_bytes(128'(dst), 4);
		// option words
		for (i = 0; i < (int'(ihl) - 5) * 4; i++)
			put_bytes(128'($urandom), 1);
	endtask

	task automatic put_ipv6(input logic [15:0] len, input logic [7:0] nh,
			input logic [127:0] src, input logic [127:0] dst);
		logic [3:0] tc;
		tc = 4'($urandom);
		put_bytes(128'({VER_IPV6, tc}), 1);
		put_bytes(128'($urandom), 3);
		put_bytes(128'(len), 2);
		put_bytes(128'(nh), 1);
		put_bytes(128'($urandom), 1);
		put_bytes(src, 16);
		put_bytes(dst, 16);
	endtask

	task automatic put_other_ver(input logic [3:0] ver);
		logic [3:0] lo;
		lo = 4'($urandom);
		put_bytes(128'({ver, lo}), 1);
	endtask

	task automatic put_tail(input int n);
		repeat (n) put_bytes(128'($urandom), 1);
	endtask

	task automatic cut_frame(input int n);
		while (frame_q.size() > n)
			void'(frame_q.pop_back());
	endtask

	task automatic test_preamble;
		// bytes before any frame start are dropped
		send_byte(8'hA5, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b0);
		put_eth(48'h0102_0304_0506, 48'h0A0B_0C0D_0E0F, 1'b0, ETH_IPV4);
		put_ipv4(4'd5, 16'd60, 8'd6, 32'hC0A8_0001, 32'h0A00_0002);
		put_tail(4);
		send_frame();
	endtask

	task automatic test_ipv4_extremes;
		put_eth('1, '1, 1'b0, 16'hFFFF);
		put_ipv4(4'hF, 16'hFFFF, 8'hFF, '1, '1);
		send_frame();
		put_eth('0, '0, 1'b0, 16'h0000);
		put_ipv4(4'h0, 16'h0000, 8'h00, '0, '0);
		send_frame();
		// hold off until the block has handed back everything
		drain();
		put_eth(48'h8000_0000_0001, 48'h0000_0000_0080, 1'b0, ETH_IPV4);
		put_ipv4(4'd7, 16'h8001, 8'd17, 32'h8000_0001, 32'h0000_0080);
		send_frame();
	endtask

	task automatic test_ipv6;
		put_eth('1, '1, 1'b0, ETH_IPV6);
		put_ipv6(16'hFFFF, 8'hFF, '1, '1);
		put_tail(3);
		send_frame();
		put_eth('0, '0, 1'b0, 16'h0000);
		put_ipv6(16'h0000, 8'h00, '0, '0);
		send_frame();
		put_eth(48'(rand_val(48)), 48'(rand_val(48)), 1'b0, ETH_IPV6);
		put_ipv6(16'd1280, 8'd58, {rand_val(64), rand_val(64)}, {rand_val(64), rand_val(64)});
		send_frame();
	endtask

	task automatic test_unknown_version;
		put_eth(48'(rand_val(48)), 48'(rand_val(48)), 1'b0, ETH_IPV4);
		put_other_ver(4'h0);
		put_tail(5);
		send_frame();
		put_eth(48'(rand_val(48)), 48'(rand_val(48)), 1'b1, ETH_IPV6);
		put_other_ver(4'hF);
		send_frame();
		put_eth(48'(rand_val(48)), 48'(rand_val(48)), 1'b0, 16'h1234);
		put_other_ver(4'h5);
		send_frame();
	endtask

	task automatic test_vlan;
		put_eth(48'(rand_val(48)), 48'(rand_val(48)), 1'b1, ETH_IPV4);
		put_ipv4(4'd5, 16'd1500, 8'd6, $urandom, $urandom);
		send_frame();
		put_eth(48'(rand_val(48)), 48'(rand_val(48)), 1'b1, ETH_IPV6);
		put_ipv6(16'd40, 8'd6, {rand_val(64), rand_val(64)}, {rand_val(64), rand_val(64)});
		send_frame();
		// stacked tags: inner tpid reported as the type, ip follows at once
		put_eth(48'(rand_val(48)), 48'(rand_val(48)), 1'b1, TPID_8021Q);
		put_ipv4(4'd5, 16'd100, 8'd1, $urandom, $urandom);
		send_frame();
	endtask

	task automatic test_short_frames;
		put_eth(48'(rand_val(48)), 48'(rand_val(48)), 1'b0, ETH_IPV4);
		put_ipv4(4'd5, 16'd64, 8'd6, $urandom, $urandom);
		cut_frame(10);
		send_frame();
		put_eth(48'(rand_val(48)), 48'(rand_val(48)), 1'b0, ETH_IPV6);
		put_ipv6(16'd8, 8'd17, {rand_val(64), rand_val(64)}, {rand_val(64), rand_val(64)});
		cut_frame(53);
		send_frame();
		put_eth(48'(rand_val(48)), 48'(rand_val(48)), 1'b1, ETH_IPV4);
		put_ipv4(4'd5, 16'd64, 8'd6, $urandom, $urandom);
		cut_frame(37);
		send_frame();
		send_byte(8'h00, 1'b1);
		put_eth(48'(rand_val(48)), 48'(rand_val(48)), 1'b0, ETH_IPV4);
		put_ipv4(4'd5, 16'd64, 8'd6, $urandom, $urandom);
		send_frame();
	endtask

	task automatic test_random;
		int kind;
		int n;
		logic vlan;
		logic [15:0] etype;
		logic [3:0] ihl;
		logic [3:0] ver;
		while (sent_bytes < ITEM_COUNT) begin
			kind = $urandom_range(0, 99);
			vlan = ($urandom_range(0, 2) == 0);
			if ($urandom_range(0, 3) == 0)
				etype = 16'($urandom);
			else
				etype = (kind >= 45 && kind < 70) ? ETH_IPV6 : ETH_IPV4;
			if (kind >= 78 && kind < 86) begin
				vlan = 1'b1;
				etype = TPID_8021Q;
			end
			put_eth(48'(rand_val(48)), 48'(rand_val(48)), vlan, etype);
			if (kind < 45 || (kind >= 78 && kind < 83)) begin
				ihl = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'd5;
				put_ipv4(ihl, 16'(rand_val(16)), 8'(rand_val(8)),
					32'(rand_val(32)), 32'(rand_val(32)));
			end else if (kind < 70 || (kind >= 83 && kind < 86)) begin
				put_ipv6(16'(rand_val(16)), 8'(rand_val(8)), {rand_val(64), rand_val(64)},
					{rand_val(64), rand_val(64)});
			end else if (kind < 78) begin
				do ver = 4'($urandom); while (ver == VER_IPV4 || ver == VER_IPV6);
				put_other_ver(ver);
			end else begin
				frame_q.delete();
				put_tail($urandom_range(1, 60));
			end
			put_tail($urandom_range(0, 6));
			if ($urandom_range(0, 9) == 0 && frame_q.size() > 1)
				cut_frame($urandom_range(1, frame_q.size() - 1));
			send_frame();
			if ($urandom_range(0, 15) == 0) begin
				n = $urandom_range(1, 4);
				repeat (n) send_byte(8'($urandom), 1'b0);
			end
			if ($urandom_range(0, 49) == 0)
				drain();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_preamble();
		test_ipv4_extremes();
		test_ipv6();
		test_unknown_version();
		test_vlan();
		test_short_frames();
		test_random();
		drain();
		repeat (20) @(negedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
